>>> hdl/grwc_pkg.sv
// Shared types, widths and helpers for the grid ray wall caster.
`timescale 1ns / 1ps
package grwc_pkg;

	// Default geometry and step limit
	localparam int DEF_GRID_WIDTH  = 8;
	localparam int DEF_GRID_HEIGHT = 8;
	localparam int DEF_MAX_STEPS   = 8;
	localparam int DEF_CELL_SHIFT  = 6;

	// Fixed point: 8 fraction bits on every position
	localparam int FRAC_BITS = 8;

	// Field widths
	localparam int COORD_W = 17;
	localparam int SLOPE_W = 16;
	localparam int HIT_W   = 20;
	localparam int MAP_W   = 64;
	localparam int MAP_IDX_W = 6;

	// Working widths, sized for the largest cell shift (8) and step limit (16):
	// start offset below 2^24, per-cell offset below 2^24, 16 steps below 2^28.
	localparam int POS_W  = 30;
	localparam int DIFF_W = 18;
	localparam int PROD_W = SLOPE_W + DIFF_W;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [SLOPE_W-1:0] slope_t;
	typedef logic signed [HIT_W-1:0]   hit_t;
	typedef logic [MAP_W-1:0]          map_t;
	typedef logic signed [POS_W-1:0]   pos_t;

	localparam logic signed [POS_W-1:0] HIT_MAX = POS_W'((1 << (HIT_W - 1)) - 1);
	localparam logic signed [POS_W-1:0] HIT_MIN = -POS_W'(1 << (HIT_W - 1));

	// Clamp a working position to the output range
	function automatic hit_t sat_hit(input pos_t v);
		hit_t r;
		if (v > HIT_MAX) begin
			r = HIT_MAX[HIT_W-1:0];
		end else if (v < HIT_MIN) begin
			r = HIT_MIN[HIT_W-1:0];
		end else begin
			r = v[HIT_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/grwc_if.sv
// Valid/ready channel interfaces for ray words and hit words.
`timescale 1ns / 1ps
interface grwc_in_if;
	import grwc_pkg::*;
	logic   valid;
	logic   ready;
	logic   operation;
	coord_t player_x;
	coord_t player_y;
	slope_t slope;
	logic   facing_negative;
	logic   axis_parallel;

	modport source(output valid, operation, player_x, player_y, slope, facing_negative,
		axis_parallel, input ready);
	modport sink(input valid, operation, player_x, player_y, slope, facing_negative,
		axis_parallel, output ready);
endinterface

interface grwc_out_if;
	import grwc_pkg::*;
	logic valid;
	logic ready;
	hit_t hit_x;
	hit_t hit_y;
	logic wall_found;

	modport source(output valid, hit_x, hit_y, wall_found, input ready);
	modport sink(input valid, hit_x, hit_y, wall_found, output ready);
endinterface

>>> hdl/grwc_cell_test.sv
// Wall bitmap lookup for one cell index pair; cells off the map read empty.
`timescale 1ns / 1ps
module grwc_cell_test #(
	parameter int GRID_WIDTH  = grwc_pkg::DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = grwc_pkg::DEF_GRID_HEIGHT,
	parameter int CIDX_W      = 16
) (
	input  grwc_pkg::map_t            wall_map,
	input  logic signed [CIDX_W-1:0]  col,
	input  logic signed [CIDX_W-1:0]  row,
	output logic                      wall
);
	import grwc_pkg::*;

	localparam logic signed [CIDX_W-1:0] W_LIM = CIDX_W'(GRID_WIDTH);
	localparam logic signed [CIDX_W-1:0] H_LIM = CIDX_W'(GRID_HEIGHT);

	logic                 in_map;
	logic [MAP_IDX_W-1:0] bit_idx;

	// Bounds check, then row-major bit select
	always_comb begin
		in_map  = (col >= 0) && (row >= 0) && (col < W_LIM) && (row < H_LIM);
		bit_idx = MAP_IDX_W'(row[2:0]) * MAP_IDX_W'(GRID_WIDTH) + MAP_IDX_W'(col[2:0]);
		wall    = in_map && wall_map[bit_idx];
	end

endmodule

>>> hdl/grid_ray_wall_cast.sv
// Top level of the grid ray wall caster: sequencer, step datapath and output register.
`timescale 1ns / 1ps
// Casts one ray per input word across a grid of (1 << CELL_SHIFT)-unit cells and
// returns where it meets a wall in the wall_map bitmap. One ray is worked at a
// time: in_ch.ready is high only while the block is idle. A word is captured,
// then passes the setup steps (gridline snap, the single 16x18 slope multiply,
// offset add) and the cell steps, at most MAX_STEPS, and its hit word is then
// shown on out_ch until out_ch.ready takes it; an axis-parallel ray goes
// straight to the output. The cell step loop sets how long a ray holds the
// block, with any output stall added. The user must write wall_map only while
// idle; the block itself does not enforce it. Written while idle, it takes
// effect on the next ray.
module grid_ray_wall_cast #(
	parameter int GRID_WIDTH  = grwc_pkg::DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = grwc_pkg::DEF_GRID_HEIGHT,
	parameter int MAX_STEPS   = grwc_pkg::DEF_MAX_STEPS,
	parameter int CELL_SHIFT  = grwc_pkg::DEF_CELL_SHIFT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wall_map_we,
	input  grwc_pkg::map_t  wall_map_data,
	grwc_in_if.sink         in_ch,
	grwc_out_if.source      out_ch
);
	import grwc_pkg::*;

	localparam int POS_SHIFT = CELL_SHIFT + FRAC_BITS;
	localparam int CIDX_W    = POS_W - POS_SHIFT + 1;
	localparam int STEP_W    = $clog2(MAX_STEPS + 1);
	localparam logic signed [POS_W-1:0] CELL = POS_W'(1) << POS_SHIFT;
	localparam logic signed [POS_W-1:0] SNAP_MASK =
		{{(POS_W - POS_SHIFT){1'b1}}, {POS_SHIFT{1'b0}}};

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SNAP = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_OFFS = 6'b001000,
		ST_STEP = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	map_t                      wall_map_q;
	logic                      horiz_q;
	logic                      neg_q;
	slope_t                    slope_q;
	pos_t                      main_q;
	pos_t                      other_q;
	pos_t                      step_other_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [STEP_W-1:0]         n_q;
	hit_t                      hit_x_q;
	hit_t                      hit_y_q;
	logic                      found_q;

	pos_t                      snap_c;
	pos_t                      main_nx;
	pos_t                      other_nx;
	pos_t                      pos_x;
	pos_t                      pos_y;
	pos_t                      end_x;
	pos_t                      end_y;
	logic signed [CIDX_W-1:0]  cx;
	logic signed [CIDX_W-1:0]  cy;
	logic signed [CIDX_W-1:0]  nb_x;
	logic signed [CIDX_W-1:0]  nb_y;
	logic                      wall_here;
	logic                      wall_behind;
	logic                      hit;
	logic                      last_step;
	logic                      accept;

	assign accept        = in_ch.valid && in_ch.ready;
	assign in_ch.ready   = (state_q == ST_IDLE);
	assign out_ch.valid  = (state_q == ST_DONE);
	assign out_ch.hit_x  = hit_x_q;
	assign out_ch.hit_y  = hit_y_q;
	assign out_ch.wall_found = found_q;

	// Wall bitmap register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q <= '0;
		end else if (wall_map_we) begin
			wall_map_q <= wall_map_data;
		end
	end

	// Snap, current cell, neighbor behind the crossed line, next point
	always_comb begin
		snap_c   = (main_q & SNAP_MASK) + (neg_q ? POS_W'(0) : CELL);
		main_nx  = neg_q ? (main_q - CELL) : (main_q + CELL);
		other_nx = other_q + step_other_q;
		pos_x    = horiz_q ? other_q : main_q;
		pos_y    = horiz_q ? main_q : other_q;
		cx       = CIDX_W'(pos_x >>> POS_SHIFT);
		cy       = CIDX_W'(pos_y >>> POS_SHIFT);
		nb_x     = horiz_q ? cx : (cx - CIDX_W'(1));
		nb_y     = horiz_q ? (cy - CIDX_W'(1)) : cy;
		hit      = wall_here || wall_behind;
		last_step = (n_q == STEP_W'(MAX_STEPS - 1));
		end_x    = hit ? pos_x : (horiz_q ? other_nx : main_nx);
		end_y    = hit ? pos_y : (horiz_q ? main_nx : other_nx);
	end

	grwc_cell_test #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.CIDX_W     (CIDX_W)
	) u_here (
		.wall_map(wall_map_q),
		.col     (cx),
		.row     (cy),
		.wall    (wall_here)
	);

	grwc_cell_test #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT),
		.CIDX_W     (CIDX_W)
	) u_behind (
		.wall_map(wall_map_q),
		.col     (nb_x),
		.row     (nb_y),
		.wall    (wall_behind)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_ch.axis_parallel ? ST_DONE : ST_SNAP;
					end
				end
				ST_SNAP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_OFFS;
				ST_OFFS: state_q <= ST_STEP;
				ST_STEP: begin
					if (hit || last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Ray datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					horiz_q      <= in_ch.operation;
					neg_q        <= in_ch.facing_negative;
					slope_q      <= in_ch.slope;
					main_q       <= POS_W'(in_ch.operation ? in_ch.player_y : in_ch.player_x);
					other_q      <= POS_W'(in_ch.operation ? in_ch.player_x : in_ch.player_y);
					step_other_q <= in_ch.facing_negative
						? -(POS_W'(in_ch.slope) <<< (POS_SHIFT - FRAC_BITS))
						: (POS_W'(in_ch.slope) <<< (POS_SHIFT - FRAC_BITS));
					n_q          <= '0;
					// axis-parallel ray returns the origin
					hit_x_q      <= HIT_W'(in_ch.player_x);
					hit_y_q      <= HIT_W'(in_ch.player_y);
					found_q      <= 1'b0;
				end
			end
			ST_SNAP: begin
				main_q <= snap_c;
				diff_q <= DIFF_W'(snap_c - main_q);
			end
			ST_MUL: begin
				prod_q <= PROD_W'(slope_q) * PROD_W'(diff_q);
			end
			ST_OFFS: begin
				other_q <= other_q + POS_W'(prod_q >>> FRAC_BITS);
			end
			ST_STEP: begin
				if (!hit) begin
					main_q  <= main_nx;
					other_q <= other_nx;
					n_q     <= n_q + STEP_W'(1);
				end
				if (hit || last_step) begin
					hit_x_q <= sat_hit(end_x);
					hit_y_q <= sat_hit(end_y);
					found_q <= hit;
				end
			end
			ST_DONE: begin
				hit_x_q <= hit_x_q;
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

endmodule
